### rtl/s2tc_pkg.sv
package s2tc_pkg;

    localparam int unsigned PIXELS     = 16;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned COLOR_W    = 16;
    localparam int unsigned BLOCK_W    = 64;
    localparam int unsigned IN_DATA_W  = 320;
    localparam int unsigned OUT_DATA_W = 128;

    localparam logic [15:0] RED_MASK   = 16'hF800;
    localparam logic [15:0] GREEN_MASK = 16'h07E0;
    localparam logic [15:0] BLUE_MASK  = 16'h001F;
    localparam logic [7:0]  NIBBLE_HI  = 8'hF0;
    localparam logic [7:0]  INDEX_LSBS = 8'h55;

    // Endpoints and luma thresholds of one block, ahead of the pixel lanes.
    typedef struct packed {
        logic [COLOR_W-1:0] color0;
        logic [COLOR_W-1:0] color1;
        logic [CHAN_W-1:0]  thr_even;
        logic [CHAN_W-1:0]  thr_odd;
    } s2tc_prep_t;

    // Moves a channel value half of the way toward the midpoint, a quarter of the way toward the other value.
    function automatic logic [CHAN_W-1:0] pull_in(input logic [CHAN_W-1:0] near,
                                                  input logic [CHAN_W-1:0] far);
        logic [CHAN_W:0]   mid_sum;
        logic [CHAN_W:0]   out_sum;
        logic [CHAN_W-1:0] mid;
        mid_sum = {1'b0, near} + {1'b0, far};
        mid     = mid_sum[CHAN_W:1];
        out_sum = {1'b0, near} + {1'b0, mid};
        return out_sum[CHAN_W:1];
    endfunction

    function automatic logic [COLOR_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
        logic [COLOR_W-1:0] word;
        word = ({r, 8'h00} & RED_MASK) | ({5'd0, g, 3'd0} & GREEN_MASK)
             | ({8'd0, b} >> 3 & BLUE_MASK);
        return word;
    endfunction

endpackage

### rtl/s2tc_prep.sv
module s2tc_prep (
    input  logic [7:0]          min_red,
    input  logic [7:0]          min_green,
    input  logic [7:0]          min_blue,
    input  logic [7:0]          max_red,
    input  logic [7:0]          max_green,
    input  logic [7:0]          max_blue,
    input  logic [7:0]          luma_min,
    input  logic [7:0]          luma_max,
    output s2tc_pkg::s2tc_prep_t prep
);

    logic [8:0] acy_sum;
    logic [7:0] acy;
    logic [9:0] acy_x3;
    logic [9:0] even_sum;
    logic [9:0] odd_sum;

    always_comb
    begin
        acy_sum  = {1'b0, luma_min} + {1'b0, luma_max};
        acy      = acy_sum[8:1];
        acy_x3   = {1'b0, acy, 1'b0} + {2'b00, acy};
        even_sum = acy_x3 + {2'b00, luma_min};
        odd_sum  = acy_x3 + {2'b00, luma_max};

        prep.color0   = s2tc_pkg::pack565(s2tc_pkg::pull_in(min_red, max_red),
                                          s2tc_pkg::pull_in(min_green, max_green),
                                          s2tc_pkg::pull_in(min_blue, max_blue));
        prep.color1   = s2tc_pkg::pack565(s2tc_pkg::pull_in(max_red, min_red),
                                          s2tc_pkg::pull_in(max_green, min_green),
                                          s2tc_pkg::pull_in(max_blue, min_blue));
        prep.thr_even = even_sum[9:2];
        prep.thr_odd  = odd_sum[9:2];
    end

endmodule

### rtl/s2tc_lane.sv
module s2tc_lane (
    input  logic [7:0] luma,
    input  logic [7:0] thr_even,
    input  logic [7:0] thr_odd,
    input  logic       odd_square,
    output logic       hit
);

    logic [7:0] thr;

    always_comb
    begin
        thr = odd_square ? thr_odd : thr_even;
        hit = (luma >= thr);
    end

endmodule

### rtl/s2tc_merge.sv
module s2tc_merge (
    input  s2tc_pkg::s2tc_prep_t               prep,
    input  logic [s2tc_pkg::PIXELS-1:0]        hits,
    output logic [s2tc_pkg::BLOCK_W-1:0]       color_block
);

    logic        swap;
    logic [31:0] idx;

    always_comb
    begin
        // Endpoints go out in ascending order; swapping them flips each index.
        swap = (prep.color0 > prep.color1);
        for (int k = 0; k < s2tc_pkg::PIXELS; k++)
        begin
            idx[2*k]   = hits[k] ^ swap;
            idx[2*k+1] = 1'b0;
        end
        if (swap)
            color_block = {idx, prep.color0, prep.color1};
        else
            color_block = {idx, prep.color1, prep.color0};
    end

endmodule

### rtl/s2tc_texture_block_encoder.sv
// An accepted item goes to prep_reg, luma_reg and alpha_pack_reg, then to out_data_reg.
// One 4x4 block per cycle, unless m_axis_tready stalls the output; the endpoint/threshold stage
// and the sixteen luma compare lanes with the endpoint-ordering merge are each one register stage.
// Reset (rst_n low, asynchronous) empties both pipeline stages and clears alpha_mode to 0.
module s2tc_texture_block_encoder (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,      // alpha_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // luma_low, luma_high, alpha_low, alpha_high, min_red, min_green, min_blue,
    // max_red, max_green, max_blue, luma_min, luma_max
    input  logic [319:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // color_block, alpha_block
);

    logic                  alpha_mode_reg;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    s2tc_pkg::s2tc_prep_t  prep_reg;
    logic [127:0]          luma_reg;
    logic [63:0]           alpha_pack_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [127:0]          out_data_reg;

    s2tc_pkg::s2tc_prep_t  prep;
    logic [63:0]           alpha_pack;
    logic [15:0]           hits;
    logic [63:0]           color_block;
    logic                  s1_advance;
    logic                  in_accept;

    s2tc_prep u_prep (
        .min_red   (s_axis_tdata[263:256]),
        .min_green (s_axis_tdata[271:264]),
        .min_blue  (s_axis_tdata[279:272]),
        .max_red   (s_axis_tdata[287:280]),
        .max_green (s_axis_tdata[295:288]),
        .max_blue  (s_axis_tdata[303:296]),
        .luma_min  (s_axis_tdata[311:304]),
        .luma_max  (s_axis_tdata[319:312]),
        .prep      (prep)
    );

    // Explicit alpha keeps the top nibble of each pixel, two pixels per byte.
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            alpha_pack[8*k +: 8] = (s_axis_tdata[128 + 16*k + 8 +: 8] & s2tc_pkg::NIBBLE_HI)
                                 | {4'd0, s_axis_tdata[128 + 16*k + 4 +: 4]};
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < s2tc_pkg::PIXELS; gi++)
        begin : g_lane
            localparam logic ODD = 1'(((gi >> 2) ^ gi) & 1);
            s2tc_lane u_lane (
                .luma       (luma_reg[8*gi +: 8]),
                .thr_even   (prep_reg.thr_even),
                .thr_odd    (prep_reg.thr_odd),
                .odd_square (ODD),
                .hit        (hits[gi])
            );
        end
    endgenerate

    s2tc_merge u_merge (
        .prep        (prep_reg),
        .hits        (hits),
        .color_block (color_block)
    );

    always_comb
    begin
        s1_advance     = s1_valid_reg && (!out_valid_reg || m_axis_tready);
        s_axis_tready  = !s1_valid_reg || s1_advance;
        in_accept      = s_axis_tvalid && s_axis_tready;
        s1_valid_next  = in_accept || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && !m_axis_tready);
        m_axis_tvalid  = out_valid_reg;
        m_axis_tdata   = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                alpha_mode_reg <= cfg_wdata;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prep_reg       <= prep;
            luma_reg       <= s_axis_tdata[127:0];
            alpha_pack_reg <= alpha_pack;
        end
        if (s1_advance)
            out_data_reg <= {alpha_mode_reg ? alpha_pack_reg : 64'd0, color_block};
    end

`ifndef SYNTH
    a_index_msb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[63:32] & 32'hAAAA_AAAA) == 32'd0))
        else $error("index high bit set in color block");

    a_endpoint_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= m_axis_tdata[31:16]))
        else $error("color endpoints out of order");

    a_bc1_alpha_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !alpha_mode_reg) |-> (m_axis_tdata[127:64] == 64'd0))
        else $error("alpha block not zero in BC1 mode");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(prep_reg)))
        else $error("stalled block lost in first stage");
`endif

endmodule
